// ===== design/erwc_pkg.sv =====
// ----------------------------------------------------------------------------
// Replay window check package
// Window size, derived widths and the tracking state type that the decision
// logic and the top level share.
// ----------------------------------------------------------------------------
package erwc_pkg;

   localparam int WINDOW_BITS = 64;
   localparam int DIST_WIDTH  = $clog2(WINDOW_BITS);
   localparam int EPOCH_WIDTH = 32;
   localparam int SEQ_WIDTH   = 32;

   typedef struct packed {
      logic                   tracking_valid;
      logic [EPOCH_WIDTH-1:0] current_epoch;
      logic [SEQ_WIDTH-1:0]   newest_sequence;
      logic [WINDOW_BITS-1:0] seen_bitmap;
   } window_state_type;

endpackage

// ===== design/erwc_decide.sv =====
// ----------------------------------------------------------------------------
// Replay window decision
// Evaluates one packet word against the tracking state and produces the
// accept bit together with the next tracking state.
// ----------------------------------------------------------------------------
module erwc_decide
   import erwc_pkg::*;
(
   input  window_state_type       state_cur,
   input  logic [EPOCH_WIDTH-1:0] sender_epoch,
   input  logic [SEQ_WIDTH-1:0]   sequence_number,
   output window_state_type       state_nxt,
   output logic                   accepted
);

   logic                   restart;
   logic                   older_epoch;
   logic                   newer_seq;
   logic [SEQ_WIDTH-1:0]   dist_up;
   logic [SEQ_WIDTH-1:0]   dist_dn;
   logic                   far_ahead;
   logic                   too_old;
   logic [WINDOW_BITS-1:0] shifted;
   logic [WINDOW_BITS-1:0] probe;
   logic                   duplicate;

   assign restart     = !state_cur.tracking_valid || (sender_epoch > state_cur.current_epoch);
   assign older_epoch = sender_epoch < state_cur.current_epoch;
   assign newer_seq   = sequence_number > state_cur.newest_sequence;
   assign dist_up     = sequence_number - state_cur.newest_sequence;
   assign dist_dn     = state_cur.newest_sequence - sequence_number;
   assign far_ahead   = dist_up >= SEQ_WIDTH'(WINDOW_BITS);
   assign too_old     = dist_dn >= SEQ_WIDTH'(WINDOW_BITS);
   assign shifted     = far_ahead ? '0 : (state_cur.seen_bitmap << dist_up[DIST_WIDTH-1:0]);
   assign probe       = WINDOW_BITS'(1) << dist_dn[DIST_WIDTH-1:0];
   assign duplicate   = |(state_cur.seen_bitmap & probe);

   always_comb begin
      state_nxt = state_cur;
      accepted  = 1'b0;
      if (restart) begin
         state_nxt.tracking_valid  = 1'b1;
         state_nxt.current_epoch   = sender_epoch;
         state_nxt.newest_sequence = sequence_number;
         state_nxt.seen_bitmap     = WINDOW_BITS'(1);
         accepted                  = 1'b1;
      end else if (older_epoch) begin
         accepted = 1'b0;
      end else if (newer_seq) begin
         state_nxt.newest_sequence = sequence_number;
         state_nxt.seen_bitmap     = shifted | WINDOW_BITS'(1);
         accepted                  = 1'b1;
      end else if (!too_old && !duplicate) begin
         state_nxt.seen_bitmap = state_cur.seen_bitmap | probe;
         accepted              = 1'b1;
      end
   end

endmodule

// ===== design/epoch_replay_window_check.sv =====
// ----------------------------------------------------------------------------
// Epoch replay window check
// Anti-replay filter with a sliding seen-bitmap and a sender epoch.
// ----------------------------------------------------------------------------
// Each request word carries a packet's sender epoch and sequence number, and
// each response word returns one accept bit, in order. The block takes one
// word per cycle while no response is stalled: the word is held in an input
// register, checked and folded into the tracking state as it leaves that
// register, and the accept bit waits in a result register. Updating the
// tracking state as each word leaves that register sets that rate.
// While a response is stalled, one further word can still be taken into the input register.
module epoch_replay_window_check
   import erwc_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic [EPOCH_WIDTH-1:0] req_sender_epoch,
   input  logic [SEQ_WIDTH-1:0]   req_sequence_number,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic                   rsp_accepted
);

   logic                   in_valid_ff;
   logic                   in_valid_in;
   logic [EPOCH_WIDTH-1:0] in_epoch_ff;
   logic [SEQ_WIDTH-1:0]   in_seq_ff;
   logic                   out_valid_ff;
   logic                   out_valid_in;
   logic                   out_accepted_ff;
   window_state_type       state_ff;
   window_state_type       state_in;
   logic                   dec_accepted;
   logic                   advance;
   logic                   stage_fire;
   logic                   req_fire;

   erwc_decide u_decide (
      .state_cur       (state_ff),
      .sender_epoch    (in_epoch_ff),
      .sequence_number (in_seq_ff),
      .state_nxt       (state_in),
      .accepted        (dec_accepted)
   );

   assign advance    = !out_valid_ff || rsp_ready;
   assign stage_fire = in_valid_ff && advance;
   assign req_ready  = !in_valid_ff || advance;
   assign req_fire   = req_valid && req_ready;

   assign in_valid_in  = req_fire || (in_valid_ff && !advance);
   assign out_valid_in = stage_fire || (out_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff             <= 1'b0;
         out_valid_ff            <= 1'b0;
         state_ff.tracking_valid <= 1'b0;
         state_ff.current_epoch  <= '0;
         state_ff.newest_sequence <= '0;
         state_ff.seen_bitmap    <= '0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         if (stage_fire) begin
            state_ff <= state_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         in_epoch_ff <= req_sender_epoch;
         in_seq_ff   <= req_sequence_number;
      end
      if (stage_fire) begin
         out_accepted_ff <= dec_accepted;
      end
   end

   assign rsp_valid    = out_valid_ff;
   assign rsp_accepted = out_accepted_ff;

   a_tracking_sticky: assert property (@(posedge clock) disable iff (reset)
      state_ff.tracking_valid |=> state_ff.tracking_valid)
      else $error("Tracking state was lost without a reset.");

   a_epoch_monotonic: assert property (@(posedge clock) disable iff (reset)
      state_ff.tracking_valid |=> state_ff.current_epoch >= $past(state_ff.current_epoch))
      else $error("Tracked epoch moved backward.");

   a_newest_marked: assert property (@(posedge clock) disable iff (reset)
      state_ff.tracking_valid |-> state_ff.seen_bitmap[0])
      else $error("Newest sequence number is not marked as seen.");

   a_reject_holds_state: assert property (@(posedge clock) disable iff (reset)
      stage_fire && !dec_accepted |=> $stable(state_ff))
      else $error("A rejected word changed the tracking state.");

   a_first_accepted: assert property (@(posedge clock) disable iff (reset)
      stage_fire && !state_ff.tracking_valid |-> dec_accepted)
      else $error("The first word after reset was rejected.");

endmodule
